// File: rtl/sia_pkg.sv
// Package for the shifting indexed array table.
// Holds operation and status codes, default sizes and the controller command struct.
// No dependencies.
package sia_pkg;

    // Default table size
    localparam int DEF_CAPACITY = 64;

    // Fixed field widths
    localparam int OP_W    = 3;
    localparam int IDX_W   = 8;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;
    localparam int COUNT_W = 7;

    // Entries per read group of the get path
    localparam int GRP_SIZE = 8;
    localparam int GRP_W    = 3;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_EDIT   = 3'd2,
        OP_DELETE = 3'd3,
        OP_GET    = 3'd4,
        OP_FIND   = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_BADINDEX = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new transaction
        logic exec;   // update cells and count, register match and read groups
        logic fin;    // load the result registers
    } sia_cmd_t;

endpackage

// File: rtl/shifting_indexed_array_table.sv
// Shifting indexed array table: packed table of signed 32-bit entries with a fill count.
// Each transaction runs an execute step that shifts the cell row, then a finish step
// that encodes the match flags and picks the read group. A new transaction can enter
// while the previous one finishes, but not during its execute step or a result stall.
// Reset: asynchronous, active low; clears the fill count and handshake state. Entry
// cells are not reset and hold nothing readable until written.
module shifting_indexed_array_table
    import sia_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     operation,
    input  logic [IDX_W-1:0]    index,
    input  logic [DATA_W-1:0]   data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ST_W-1:0]     status,
    output logic [DATA_W-1:0]   read_value,
    output logic [COUNT_W-1:0]  element_count,
    output logic                is_empty,
    output logic                is_full
);

    sia_cmd_t cmd;

    sia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sia_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .index         (index),
        .data          (data),
        .status        (status),
        .read_value    (read_value),
        .element_count (element_count),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

endmodule

// File: rtl/sia_ctrl.sv
// Controller for the shifting indexed array table.
// Sequences load, execute and finish steps and owns the output valid flag.
// Depends on sia_pkg.
module sia_ctrl
    import sia_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output sia_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // Result slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || out_ready;

    // A new transaction may enter while the previous one finishes
    assign in_ready = (state_reg == S_IDLE) || ((state_reg == S_FIN) && out_free);

    assign cmd.load = in_valid && in_ready;
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.fin  = (state_reg == S_FIN) && out_free;

    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = cmd.load ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/sia_datapath.sv
// Datapath for the shifting indexed array table.
// Row of entry cells with shift insert/delete, match flags, grouped read and result registers.
// Depends on sia_pkg.
module sia_datapath
    import sia_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sia_cmd_t            cmd,
    input  logic [OP_W-1:0]     operation,
    input  logic [IDX_W-1:0]    index,
    input  logic [DATA_W-1:0]   data,
    output logic [ST_W-1:0]     status,
    output logic [DATA_W-1:0]   read_value,
    output logic [COUNT_W-1:0]  element_count,
    output logic                is_empty,
    output logic                is_full
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int NGRP   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GSEL_W = IDX_W - GRP_W;

    // Transaction registers
    logic [OP_W-1:0]   op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] data_reg;

    // Table state
    logic [DATA_W-1:0] cell_reg [CAPACITY];
    logic [DATA_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg, count_next;

    // Execute-stage results
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [DATA_W-1:0]   grp_reg [NGRP];
    logic [DATA_W-1:0]   grp_next [NGRP];
    status_t             st_reg, st_next;

    // Result registers; the count flags are held with the result so a
    // following transaction cannot disturb a result that is still waiting
    logic [ST_W-1:0]    status_reg;
    logic [DATA_W-1:0]  read_value_reg;
    logic [COUNT_W-1:0] element_count_reg;
    logic               is_empty_reg;
    logic               is_full_reg;

    // Decode controls
    logic [IDX_W:0]    idx_ext, cnt_ext;
    logic              idx_lt, idx_le, tbl_full;
    logic              do_ins, do_del, do_edit;
    logic [ADDR_W-1:0] pos;

    // Capture transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            idx_reg  <= index;
            data_reg <= data;
        end
    end

    assign idx_ext  = {1'b0, idx_reg};
    assign cnt_ext  = (IDX_W + 1)'(count_reg);
    assign idx_lt   = idx_ext < cnt_ext;
    assign idx_le   = idx_ext <= cnt_ext;
    assign tbl_full = (count_reg == CNT_W'(CAPACITY));

    // Operation decode: status, count and cell write controls
    always_comb
    begin
        st_next    = ST_OK;
        count_next = count_reg;
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_edit    = 1'b0;
        pos        = idx_reg[ADDR_W-1:0];
        case (op_t'(op_reg))
            OP_APPEND:
            begin
                pos = count_reg[ADDR_W-1:0];
                if (tbl_full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (!idx_le)
                begin
                    st_next = ST_BADINDEX;
                end
                else if (tbl_full)
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_EDIT:
            begin
                if (!idx_lt)
                begin
                    st_next = ST_BADINDEX;
                end
                else
                begin
                    do_edit = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (!idx_lt)
                begin
                    st_next = ST_BADINDEX;
                end
                else
                begin
                    do_del     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_GET:
            begin
                if (!idx_lt)
                begin
                    st_next = ST_BADINDEX;
                end
            end
            OP_FIND:
            begin
                st_next = ST_NOTFOUND;  // resolved from match flags in finish step
            end
            default:
            begin
                st_next = ST_OK;
            end
        endcase
    end

    // Per-cell next value: shift up, shift down, overwrite or hold
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_val, right_val;
        logic              at_pos, above_pos;

        if (i > 0)
        begin : g_left
            assign left_val = cell_reg[i-1];
        end
        else
        begin : g_noleft
            assign left_val = cell_reg[i];
        end

        if (i < CAPACITY - 1)
        begin : g_right
            assign right_val = cell_reg[i+1];
        end
        else
        begin : g_noright
            assign right_val = cell_reg[i];
        end

        assign at_pos    = (pos == ADDR_W'(i));
        assign above_pos = (ADDR_W'(i) > pos);

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (do_ins && at_pos)
            begin
                cell_next[i] = data_reg;
            end
            else if (do_ins && above_pos)
            begin
                cell_next[i] = left_val;
            end
            else if (do_del && (at_pos || above_pos))
            begin
                cell_next[i] = right_val;
            end
            else if (do_edit && at_pos)
            begin
                cell_next[i] = data_reg;
            end
        end

        // Match flag against live entries only
        assign match_next[i] = (cell_reg[i] == data_reg) && (CNT_W'(i) < count_reg);

        always_ff @(posedge clk)
        begin
            if (cmd.exec)
            begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // First read level: one entry per group, chosen by the low index bits
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                if ((g * GRP_SIZE + k < CAPACITY) && (idx_reg[GRP_W-1:0] == GRP_W'(k)))
                begin
                    grp_next[g] = cell_reg[g * GRP_SIZE + k];
                end
            end
        end
    end

    // Execute-stage registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            match_reg <= match_next;
            grp_reg   <= grp_next;
            st_reg    <= st_next;
        end
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    // Finish step: lowest match and second read level
    logic [ADDR_W-1:0] find_pos;
    logic              find_hit;
    logic [DATA_W-1:0] get_val;
    logic [ST_W-1:0]   status_next;
    logic [DATA_W-1:0] read_value_next;

    always_comb
    begin
        find_pos = '0;
        find_hit = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                find_pos = ADDR_W'(i);
                find_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        get_val = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (idx_reg[IDX_W-1:GRP_W] == GSEL_W'(g))
            begin
                get_val = grp_reg[g];
            end
        end
    end

    always_comb
    begin
        status_next     = st_reg;
        read_value_next = '0;
        case (op_t'(op_reg))
            OP_FIND:
            begin
                status_next     = find_hit ? ST_OK : ST_NOTFOUND;
                read_value_next = find_hit ? DATA_W'(find_pos) : '0;
            end
            OP_GET:
            begin
                if (st_reg == ST_OK)
                begin
                    read_value_next = get_val;
                end
            end
            default:
            begin
                read_value_next = '0;
            end
        endcase
    end

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            status_reg        <= status_next;
            read_value_reg    <= read_value_next;
            element_count_reg <= COUNT_W'(count_reg);
            is_empty_reg      <= (count_reg == '0);
            is_full_reg       <= tbl_full;
        end
    end

    assign status        = status_reg;
    assign read_value    = read_value_reg;
    assign element_count = element_count_reg;
    assign is_empty      = is_empty_reg;
    assign is_full       = is_full_reg;

endmodule

// File: bench/tb_shifting_indexed_array_table.sv
`timescale 1ns / 1ps
// Testbench for shifting_indexed_array_table: directed and random table operations
// checked against a shadow copy of the table kept in the bench.
// Depends on sia_pkg and the shifting_indexed_array_table RTL.
module tb_shifting_indexed_array_table;
    import sia_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 20;

    // Operation codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // Operation mixes for the random part
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_STEADY} op_mix_t;

    // Receiver stall patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_RARE_STALL} rx_mode_t;

    typedef struct {
        status_t            status;
        logic [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0] element_count;
        logic               is_empty;
        logic               is_full;
    } table_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    operation = '0;
    logic [IDX_W-1:0]   index = '0;
    logic [DATA_W-1:0]  data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ST_W-1:0]    status;
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] element_count;
    logic               is_empty;
    logic               is_full;

    // Shadow table and pending replies
    logic [DATA_W-1:0]  table_copy [CAPACITY];
    int                 table_fill = 0;
    table_reply_t       pending_replies[$];

    int   error_count    = 0;
    int   accepted_count = 0;
    int   burst_left     = 0;
    logic hold_req       = 1'b0;

    shifting_indexed_array_table #(.CAPACITY(CAPACITY)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .index         (index),
        .data          (data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .read_value    (read_value),
        .element_count (element_count),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one operation to the shadow table and return the reply it should give
    function automatic table_reply_t apply_table_op(input logic [OP_W-1:0] op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [DATA_W-1:0] value);
        table_reply_t reply;
        int           pos;
        int           slot;
        slot = int'(idx);
        reply.status     = ST_OK;
        reply.read_value = '0;
        case (op)
            OP_APPEND:
            begin
                if (table_fill >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    table_copy[table_fill] = value;
                    table_fill++;
                end
            end
            OP_INSERT:
            begin
                // index check comes before the full check
                if (slot > table_fill)
                    reply.status = ST_BADINDEX;
                else if (table_fill >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    for (pos = table_fill; pos > slot; pos--)
                        table_copy[pos] = table_copy[pos-1];
                    table_copy[slot] = value;
                    table_fill++;
                end
            end
            OP_EDIT:
            begin
                if (slot >= table_fill)
                    reply.status = ST_BADINDEX;
                else
                    table_copy[slot] = value;
            end
            OP_DELETE:
            begin
                if (slot >= table_fill)
                    reply.status = ST_BADINDEX;
                else
                begin
                    for (pos = slot; pos + 1 < table_fill; pos++)
                        table_copy[pos] = table_copy[pos+1];
                    table_fill--;
                end
            end
            OP_GET:
            begin
                if (slot >= table_fill)
                    reply.status = ST_BADINDEX;
                else
                    reply.read_value = table_copy[slot];
            end
            OP_FIND:
            begin
                // lowest matching position wins
                reply.status = ST_NOTFOUND;
                for (pos = 0; pos < table_fill; pos++)
                begin
                    if (table_copy[pos] == value)
                    begin
                        reply.status     = ST_OK;
                        reply.read_value = DATA_W'(pos);
                        break;
                    end
                end
            end
            default:
            begin
                reply.status = ST_OK;
            end
        endcase
        reply.element_count = COUNT_W'(table_fill);
        reply.is_empty      = (table_fill == 0);
        reply.is_full       = (table_fill == CAPACITY);
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("ERROR at %0t: %s got 0x%h expected 0x%h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one transaction, in bursts with random gaps, and hold it until accepted
    task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        index     <= idx;
        data      <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.push_back(apply_table_op(op, idx, value));
        burst_left--;
        accepted_count++;
    endtask

    function automatic logic [OP_W-1:0] pick_op(input op_mix_t mix);
        int roll;
        int cut [6];
        roll = $urandom_range(0, 99);
        // cumulative weights: append, insert, edit, delete, get, find; rest spare
        case (mix)
            MIX_GROW:   cut = '{35, 60, 70, 75, 85, 97};
            MIX_SHRINK: cut = '{5, 10, 20, 65, 80, 97};
            default:    cut = '{20, 40, 55, 70, 80, 95};
        endcase
        if (roll < cut[0]) return OP_APPEND;
        if (roll < cut[1]) return OP_INSERT;
        if (roll < cut[2]) return OP_EDIT;
        if (roll < cut[3]) return OP_DELETE;
        if (roll < cut[4]) return OP_GET;
        if (roll < cut[5]) return OP_FIND;
        return ($urandom_range(0, 1) == 1) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index(input logic [OP_W-1:0] op);
        int roll;
        int top;
        roll = $urandom_range(0, 19);
        // insert may target one past the last entry
        top = (op == OP_INSERT) ? table_fill : table_fill - 1;
        if (roll < 14 && top >= 0)
            return IDX_W'($urandom_range(0, top));
        if (roll < 17)
            return IDX_W'(table_fill + $urandom_range(0, 1));
        return IDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input logic [OP_W-1:0] op);
        int roll;
        roll = $urandom_range(0, 9);
        // finds mostly look for a value that is present
        if (op == OP_FIND && table_fill > 0 && roll < 6)
            return table_copy[$urandom_range(0, table_fill - 1)];
        // a small pool gives duplicates
        if (roll < 5)
        begin
            case ($urandom_range(0, 7))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                3:       return 32'h0000_0000;
                default: return DATA_W'($urandom_range(1, 5));
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_random(input op_mix_t mix);
        logic [OP_W-1:0] op;
        op = pick_op(mix);
        send_item(op, pick_index(op), pick_value(op));
    endtask

    // Every operation but append on an empty table, bad indices and the spare codes
    task automatic test_empty_table();
        send_item(OP_GET,    8'd0,   32'h0000_0000);
        send_item(OP_DELETE, 8'd0,   32'h0000_0000);
        send_item(OP_EDIT,   8'd0,   32'h1234_5678);
        send_item(OP_FIND,   8'd0,   32'h0000_0000);
        send_item(OP_INSERT, 8'd1,   32'h0000_0001);
        send_item(OP_INSERT, 8'd255, 32'hffff_ffff);
        send_item(OP_SPARE_A, 8'd0,  32'h0000_0000);
        send_item(OP_SPARE_B, 8'd255, 32'hffff_ffff);
    endtask

    // Field extremes, shifts at both ends, duplicate finds, out-of-range access
    task automatic test_small_table();
        send_item(OP_INSERT, 8'd0,   32'h7fff_ffff);
        send_item(OP_APPEND, 8'd255, 32'h8000_0000);
        send_item(OP_INSERT, 8'd2,   32'hffff_ffff);
        send_item(OP_INSERT, 8'd1,   32'h0000_0000);
        send_item(OP_APPEND, 8'd0,   32'hffff_ffff);
        send_item(OP_FIND,   8'd0,   32'hffff_ffff);
        send_item(OP_FIND,   8'd0,   32'h1234_5678);
        send_item(OP_GET,    8'd0,   32'h0000_0000);
        send_item(OP_GET,    8'd4,   32'h0000_0000);
        send_item(OP_GET,    8'd5,   32'h0000_0000);
        send_item(OP_GET,    8'd255, 32'h0000_0000);
        send_item(OP_EDIT,   8'd4,   32'h7fff_ffff);
        send_item(OP_EDIT,   8'd5,   32'h0000_0000);
        send_item(OP_DELETE, 8'd0,   32'h0000_0000);
        send_item(OP_DELETE, 8'd3,   32'h0000_0000);
        send_item(OP_DELETE, 8'd9,   32'h0000_0000);
        send_item(OP_FIND,   8'd0,   32'h8000_0000);
    endtask

    // Long output stall while the sender keeps offering, so the input backs up
    task automatic test_output_backpressure();
        int n;
        hold_req = 1'b1;
        for (n = 0; n < 24; n++)
            send_random(MIX_STEADY);
    endtask

    // Fill to capacity, work at full, drain to empty, work at empty; repeat
    task automatic test_random_ops();
        int stop_at;
        int n;
        stop_at = accepted_count + RANDOM_ITEMS;
        while (accepted_count < stop_at)
        begin
            while (table_fill < CAPACITY)
                send_random(MIX_GROW);
            for (n = 0; n < 12; n++)
                send_random(MIX_STEADY);
            while (table_fill > 0)
                send_random(MIX_SHRINK);
            for (n = 0; n < 6; n++)
                send_random(MIX_STEADY);
            for (n = 0; n < 40; n++)
                send_random(MIX_STEADY);
        end
    endtask

    // Receiver: own stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        int       tick;
        int       hold_cnt;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(30, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_OPEN:         out_ready <= 1'b1;
                    RX_COIN:         out_ready <= ($urandom_range(0, 1) == 1);
                    RX_EVERY_FOURTH: out_ready <= (tick % 4 == 0);
                    default:         out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Result check against the oldest pending reply
    always @(posedge clk)
    begin
        table_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
                report_mismatch("unexpected result, status", DATA_W'(status), '0);
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status)
                    report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
                if (read_value !== want.read_value)
                    report_mismatch("read_value", read_value, want.read_value);
                if (element_count !== want.element_count)
                    report_mismatch("element_count", DATA_W'(element_count),
                                    DATA_W'(want.element_count));
                if (is_empty !== want.is_empty)
                    report_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(want.is_empty));
                if (is_full !== want.is_full)
                    report_mismatch("is_full", DATA_W'(is_full), DATA_W'(want.is_full));
            end
        end
    end

    // Sequence of tests
    initial
    begin
        int drain_cycles;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_small_table();
        test_output_backpressure();
        test_random_ops();

        in_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_replies.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
            report_mismatch("results never arrived, count", DATA_W'(pending_replies.size()),
                            '0);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
